/* rtl/qsgf_pkg.sv */
// Package of the quaternion sample glitch filter: widths, commands, status and helpers.
package qsgf_pkg;

	localparam int unsigned DIV_STEPS   = 59;
	localparam int unsigned SQRT_STEPS  = 31;
	localparam int unsigned COS_TERMS   = 6;
	localparam int unsigned ANGLE_LIMBS = 4;
	localparam int unsigned COS_LIMBS   = 2;

	localparam logic [32:0] ONE_Q28     = 33'd268435456;
	localparam logic [29:0] ONE_Q29     = 30'd536870912;
	localparam logic [58:0] HALF_PI_Q29 = 59'd843314857;

	// Division by a small constant runs on 16-bit limbs: the quotient digit is the limb value
	// times ceil(2^32 / divisor), shifted down by 32.
	localparam logic [7:0]  RATE_DIV       = 8'd125;
	localparam logic [31:0] RATE_DIV_MAGIC = 32'd34359739;

	typedef enum logic [2:0] {
		REG_BASE_ANGLE  = 3'd0,
		REG_RATE_GAIN   = 3'd1,
		REG_NORM_LOW    = 3'd2,
		REG_NORM_HIGH   = 3'd3,
		REG_RENORM_TOL  = 3'd4,
		REG_DT_MIN      = 3'd5,
		REG_DT_MAX      = 3'd6,
		REG_CONSEC_LIM  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT   = 2'd0,
		VERDICT_REUSED   = 2'd1,
		VERDICT_NORM_REJ = 2'd2,
		VERDICT_JUMP_REJ = 2'd3
	} verdict_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_MUL,
		OP_ACC,
		OP_NCHK,
		OP_SQRT_STEP,
		OP_DIVQ_LOAD,
		OP_DIV_STEP,
		OP_QWR,
		OP_DOT_MUL,
		OP_DOT_FIN,
		OP_GM1,
		OP_GM2,
		OP_GDIV_LOAD,
		OP_MFIN,
		OP_X2_MUL,
		OP_X2_WR,
		OP_C_MUL,
		OP_CDIV_LOAD,
		OP_CW,
		OP_DECIDE,
		OP_FIN,
		OP_LIMB_MUL,
		OP_LIMB_WR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic [2:0] k;
		logic       in_ready;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic norm_ok;
		logic need_renorm;
		logic skip_jump;
		logic out_busy;
	} status_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		abs16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic [7:0] cos_div(input logic [2:0] k);
		case (k)
			3'd0: cos_div = 8'd132;
			3'd1: cos_div = 8'd90;
			3'd2: cos_div = 8'd56;
			3'd3: cos_div = 8'd30;
			3'd4: cos_div = 8'd12;
			3'd5: cos_div = 8'd2;
			default: cos_div = 8'd2;
		endcase
	endfunction

	function automatic logic [31:0] cos_magic(input logic [2:0] k);
		case (k)
			3'd0: cos_magic = 32'd32537632;
			3'd1: cos_magic = 32'd47721859;
			3'd2: cos_magic = 32'd76695845;
			3'd3: cos_magic = 32'd143165577;
			3'd4: cos_magic = 32'd357913942;
			3'd5: cos_magic = 32'd2147483648;
			default: cos_magic = 32'd2147483648;
		endcase
	endfunction

endpackage

/* rtl/qsgf_in_if.sv */
// Input channel of the filter: one raw orientation sample per beat.
interface qsgf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_w;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	logic signed [15:0] raw_z;
	logic               read_ok;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	logic [31:0]        now_ms;

	modport source (output valid, raw_w, raw_x, raw_y, raw_z, read_ok, rate_x, rate_y, rate_z,
		now_ms, input ready);
	modport sink (input valid, raw_w, raw_x, raw_y, raw_z, read_ok, rate_x, rate_y, rate_z,
		now_ms, output ready);
endinterface

/* rtl/qsgf_out_if.sv */
// Output channel of the filter: one verdict and held state per beat.
interface qsgf_out_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [1:0]         verdict;
	logic signed [15:0] held_w;
	logic signed [15:0] held_x;
	logic signed [15:0] held_y;
	logic signed [15:0] held_z;
	logic [31:0]        update_seq;
	logic [7:0]         consec_discards;
	logic [31:0]        total_discards;
	logic [31:0]        total_read_fails;

	modport source (output valid, accepted, verdict, held_w, held_x, held_y, held_z, update_seq,
		consec_discards, total_discards, total_read_fails, input ready);
	modport sink (input valid, accepted, verdict, held_w, held_x, held_y, held_z, update_seq,
		consec_discards, total_discards, total_read_fails, output ready);
endinterface

/* rtl/qsgf_dp.sv */
// Datapath of the filter: shared multiplier, serial square root and divider, state and counters.
module qsgf_dp
	import qsgf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [32:0] cfg_wdata,
	qsgf_in_if.sink     in_ch,
	qsgf_out_if.source  out_ch
);

	logic [15:0] base_q;
	logic [7:0]  gain_q;
	logic [32:0] nlow_q;
	logic [32:0] nhigh_q;
	logic [28:0] tol_q;
	logic [15:0] dtmin_q;
	logic [15:0] dtmax_q;
	logic [7:0]  climit_q;

	logic signed [15:0] q_q [4];
	logic signed [15:0] h_q [4];
	logic [31:0] last_q;
	logic [7:0]  consec_q;
	logic [31:0] seq_q;
	logic [31:0] disc_q;
	logic [31:0] fail_q;

	logic        rok_q;
	logic [31:0] now_q;
	logic [16:0] g_q;

	logic signed [65:0] prod_q;
	logic signed [35:0] acc_q;
	logic [61:0] rad_q;
	logic [30:0] root_q;
	logic [32:0] srem_q;
	logic [58:0] dnum_q;
	logic [31:0] drem_q;
	logic [30:0] den_q;
	logic        neg_q;
	logic [63:0] cnum_q;
	logic [7:0]  crem_q;
	logic [7:0]  cden_q;
	logic [31:0] cmag_q;
	logic [28:0] dot_q;
	logic [15:0] dt_q;
	logic [29:0] x_q;
	logic [30:0] x2_q;
	logic [29:0] t_q;
	logic        skip_q;
	logic        norm_ok_q;
	logic        ok_q;
	logic [1:0]  verdict_q;
	logic        out_valid_q;

	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic [32:0] n2;
	logic [32:0] ndiff;
	logic        nok;
	logic        nren;
	logic [34:0] strem;
	logic [34:0] strial;
	logic [32:0] dtry;
	logic        accept_in;
	logic signed [15:0] qsel;
	logic [35:0] dabs;
	logic [31:0] dtv;
	logic [31:0] dtlo;
	logic [59:0] msum;
	logic [58:0] xfull;
	logic [15:0] qmag;
	logic [43:0] qnum;
	logic [15:0] qres;
	logic [23:0] cv;
	logic [15:0] climb;
	logic [15:0] cqd;

	assign accept_in = in_ch.valid && cmd.in_ready;
	assign in_ch.ready = cmd.in_ready;
	assign qsel = q_q[cmd.idx];

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_SQ_MUL: begin
				ma = 33'(qsel);
				mb = 33'(qsel);
			end
			OP_DOT_MUL: begin
				ma = 33'(qsel);
				mb = 33'(h_q[cmd.idx]);
			end
			OP_GM1: begin
				ma = $signed({16'd0, g_q});
				mb = $signed({25'd0, gain_q});
			end
			OP_GM2: begin
				ma = $signed({8'd0, prod_q[24:0]});
				mb = $signed({17'd0, dt_q});
			end
			OP_X2_MUL: begin
				ma = $signed({3'd0, x_q});
				mb = $signed({3'd0, x_q});
			end
			OP_C_MUL: begin
				ma = $signed({2'd0, x2_q});
				mb = $signed({3'd0, t_q});
			end
			OP_LIMB_MUL: begin
				ma = $signed({9'd0, cv});
				mb = $signed({1'b0, cmag_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign n2     = acc_q[32:0];
	assign ndiff  = (n2 > ONE_Q28) ? (n2 - ONE_Q28) : (ONE_Q28 - n2);
	assign nok    = (n2 > nlow_q) && (n2 < nhigh_q);
	assign nren   = ndiff > 33'(tol_q);
	assign strem  = {srem_q, rad_q[61:60]};
	assign strial = {2'd0, root_q, 2'b01};
	assign dtry   = {drem_q, dnum_q[58]};
	assign dabs   = acc_q[35] ? 36'(-acc_q) : 36'(acc_q);
	assign dtv    = now_q - last_q;
	assign dtlo   = (dtv < 32'(dtmin_q)) ? 32'(dtmin_q) : dtv;
	assign msum   = 60'({base_q, 16'd0}) + 60'(cnum_q);
	assign xfull  = msum[59:1];
	assign qmag   = abs16(qsel);
	assign qnum   = {qmag, 28'd0} + 44'(root_q[30:1]);
	assign qres   = neg_q ? ((dnum_q > 59'd32768) ? 16'h8000 : 16'(-dnum_q[15:0]))
	                      : ((dnum_q > 59'd32767) ? 16'h7fff : dnum_q[15:0]);
	assign cv     = {crem_q, cnum_q[63:48]};
	assign climb  = prod_q[47:32];
	assign cqd    = cden_q * climb[7:0];

	assign status.in_valid    = in_ch.valid;
	assign status.norm_ok     = nok;
	assign status.need_renorm = nren;
	assign status.skip_jump   = skip_q;
	assign status.out_busy    = out_valid_q && !out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= 16'd2130;
			gain_q   <= 8'd24;
			nlow_q   <= 33'd134217728;
			nhigh_q  <= 33'd536870912;
			tol_q    <= 29'd26844;
			dtmin_q  <= 16'd10;
			dtmax_q  <= 16'd500;
			climit_q <= 8'd10;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_ANGLE: base_q   <= cfg_wdata[15:0];
				REG_RATE_GAIN:  gain_q   <= cfg_wdata[7:0];
				REG_NORM_LOW:   nlow_q   <= cfg_wdata;
				REG_NORM_HIGH:  nhigh_q  <= cfg_wdata;
				REG_RENORM_TOL: tol_q    <= cfg_wdata[28:0];
				REG_DT_MIN:     dtmin_q  <= cfg_wdata[15:0];
				REG_DT_MAX:     dtmax_q  <= cfg_wdata[15:0];
				REG_CONSEC_LIM: climit_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd.op)
			OP_LOAD: begin
				if (accept_in) begin
					rok_q <= in_ch.read_ok;
					now_q <= in_ch.now_ms;
					g_q   <= 17'(abs16(in_ch.rate_x)) + 17'(abs16(in_ch.rate_y))
					       + 17'(abs16(in_ch.rate_z));
					acc_q <= '0;
					if (in_ch.read_ok) begin
						q_q[0] <= in_ch.raw_w;
						q_q[1] <= in_ch.raw_x;
						q_q[2] <= in_ch.raw_y;
						q_q[3] <= in_ch.raw_z;
					end else begin
						q_q <= h_q;
					end
				end
			end
			OP_ACC: acc_q <= acc_q + prod_q[35:0];
			OP_NCHK: begin
				norm_ok_q <= nok;
				ok_q      <= nok;
				verdict_q <= VERDICT_NORM_REJ;
				rad_q     <= {1'b0, n2, 28'd0};
				root_q    <= '0;
				srem_q    <= '0;
				acc_q     <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q <= {rad_q[59:0], 2'b00};
				if (strem >= strial) begin
					srem_q <= 33'(strem - strial);
					root_q <= {root_q[29:0], 1'b1};
				end else begin
					srem_q <= strem[32:0];
					root_q <= {root_q[29:0], 1'b0};
				end
			end
			OP_DIVQ_LOAD: begin
				dnum_q <= 59'(qnum);
				den_q  <= root_q;
				drem_q <= '0;
				neg_q  <= qsel[15];
			end
			OP_DIV_STEP: begin
				if (dtry >= 33'(den_q)) begin
					drem_q <= 32'(dtry - 33'(den_q));
					dnum_q <= {dnum_q[57:0], 1'b1};
				end else begin
					drem_q <= dtry[31:0];
					dnum_q <= {dnum_q[57:0], 1'b0};
				end
			end
			OP_QWR: q_q[cmd.idx] <= qres;
			OP_DOT_FIN: begin
				dot_q <= (dabs > 36'(ONE_Q28)) ? ONE_Q28[28:0] : dabs[28:0];
				dt_q  <= (dtlo > 32'(dtmax_q)) ? dtmax_q : dtlo[15:0];
			end
			OP_GDIV_LOAD: begin
				cnum_q <= {5'd0, prod_q[40:0], 18'd0};
				crem_q <= '0;
				cden_q <= RATE_DIV;
				cmag_q <= RATE_DIV_MAGIC;
			end
			OP_LIMB_WR: begin
				cnum_q <= {cnum_q[47:0], climb};
				crem_q <= cv[7:0] - cqd[7:0];
			end
			OP_MFIN: begin
				skip_q <= xfull >= HALF_PI_Q29;
				x_q    <= xfull[29:0];
			end
			OP_X2_WR: begin
				x2_q <= prod_q[59:29];
				t_q  <= ONE_Q29;
			end
			OP_CDIV_LOAD: begin
				cnum_q <= {1'b0, prod_q[59:29], 32'd0};
				crem_q <= '0;
				cden_q <= cos_div(cmd.k);
				cmag_q <= cos_magic(cmd.k);
			end
			OP_CW: t_q <= (cnum_q > 64'(ONE_Q29)) ? 30'd0 : 30'(ONE_Q29 - cnum_q[29:0]);
			OP_DECIDE: begin
				if (!skip_q && ({dot_q, 1'b0} < 30'(t_q)) && (consec_q < climit_q)) begin
					ok_q      <= 1'b0;
					verdict_q <= VERDICT_JUMP_REJ;
				end else begin
					ok_q      <= 1'b1;
					verdict_q <= rok_q ? VERDICT_ACCEPT : VERDICT_REUSED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0]      <= 16'sd16384;
			h_q[1]      <= '0;
			h_q[2]      <= '0;
			h_q[3]      <= '0;
			last_q      <= '0;
			consec_q    <= '0;
			seq_q       <= '0;
			disc_q      <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.op == OP_FIN) || (out_valid_q && !out_ch.ready);
			if (cmd.op == OP_LOAD && accept_in && !in_ch.read_ok && fail_q != '1) begin
				fail_q <= fail_q + 32'd1;
			end
			if (cmd.op == OP_FIN) begin
				if (ok_q) begin
					h_q      <= q_q;
					seq_q    <= seq_q + 32'd1;
					consec_q <= '0;
					last_q   <= now_q;
				end else begin
					if (disc_q != '1) begin
						disc_q <= disc_q + 32'd1;
					end
					if (consec_q != '1) begin
						consec_q <= consec_q + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIN) begin
			out_ch.accepted <= ok_q;
			out_ch.verdict  <= ok_q ? (rok_q ? VERDICT_ACCEPT : VERDICT_REUSED)
			                        : (norm_ok_q ? verdict_q : VERDICT_NORM_REJ);
			out_ch.held_w   <= ok_q ? q_q[0] : h_q[0];
			out_ch.held_x   <= ok_q ? q_q[1] : h_q[1];
			out_ch.held_y   <= ok_q ? q_q[2] : h_q[2];
			out_ch.held_z   <= ok_q ? q_q[3] : h_q[3];
			out_ch.update_seq       <= ok_q ? seq_q + 32'd1 : seq_q;
			out_ch.consec_discards  <= ok_q ? 8'd0 : ((consec_q != '1) ? consec_q + 8'd1 : consec_q);
			out_ch.total_discards   <= (ok_q || disc_q == '1) ? disc_q : disc_q + 32'd1;
			out_ch.total_read_fails <= fail_q;
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

/* rtl/qsgf_ctrl.sv */
// Controller of the filter: steps the datapath through norm, renormalize, dot, angle and cosine.
module qsgf_ctrl
	import qsgf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [25:0] {
		S_IDLE = 26'd1 << 0,
		S_SQM  = 26'd1 << 1,
		S_SQA  = 26'd1 << 2,
		S_NCHK = 26'd1 << 3,
		S_SQRT = 26'd1 << 4,
		S_DVL  = 26'd1 << 5,
		S_QDIV = 26'd1 << 6,
		S_QWR  = 26'd1 << 7,
		S_DOTM = 26'd1 << 8,
		S_DOTA = 26'd1 << 9,
		S_DOTF = 26'd1 << 10,
		S_GM1  = 26'd1 << 11,
		S_GM2  = 26'd1 << 12,
		S_GDL  = 26'd1 << 13,
		S_GLM  = 26'd1 << 14,
		S_MFIN = 26'd1 << 15,
		S_X2M  = 26'd1 << 16,
		S_X2W  = 26'd1 << 17,
		S_CM   = 26'd1 << 18,
		S_CDL  = 26'd1 << 19,
		S_CLM  = 26'd1 << 20,
		S_CW   = 26'd1 << 21,
		S_DEC  = 26'd1 << 22,
		S_FIN  = 26'd1 << 23,
		S_GLW  = 26'd1 << 24,
		S_CLW  = 26'd1 << 25
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [5:0] cnt_q, cnt_d;
	logic [2:0] k_q, k_d;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		cmd.op       = OP_NONE;
		cmd.idx      = idx_q;
		cmd.k        = k_q;
		cmd.in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.op       = OP_LOAD;
				cmd.in_ready = 1'b1;
				idx_d        = '0;
				if (status.in_valid) begin
					state_d = S_SQM;
				end
			end
			S_SQM: begin
				cmd.op  = OP_SQ_MUL;
				state_d = S_SQA;
			end
			S_SQA: begin
				cmd.op = OP_ACC;
				idx_d  = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? S_NCHK : S_SQM;
			end
			S_NCHK: begin
				cmd.op = OP_NCHK;
				idx_d  = '0;
				cnt_d  = '0;
				if (!status.norm_ok) begin
					state_d = S_FIN;
				end else if (status.need_renorm) begin
					state_d = S_SQRT;
				end else begin
					state_d = S_DOTM;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == 6'(SQRT_STEPS - 1)) begin
					state_d = S_DVL;
				end
			end
			S_DVL: begin
				cmd.op  = OP_DIVQ_LOAD;
				cnt_d   = '0;
				state_d = S_QDIV;
			end
			S_QDIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					state_d = S_QWR;
				end
			end
			S_QWR: begin
				cmd.op  = OP_QWR;
				idx_d   = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? S_DOTM : S_DVL;
			end
			S_DOTM: begin
				cmd.op  = OP_DOT_MUL;
				state_d = S_DOTA;
			end
			S_DOTA: begin
				cmd.op  = OP_ACC;
				idx_d   = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? S_DOTF : S_DOTM;
			end
			S_DOTF: begin
				cmd.op  = OP_DOT_FIN;
				state_d = S_GM1;
			end
			S_GM1: begin
				cmd.op  = OP_GM1;
				state_d = S_GM2;
			end
			S_GM2: begin
				cmd.op  = OP_GM2;
				state_d = S_GDL;
			end
			S_GDL: begin
				cmd.op  = OP_GDIV_LOAD;
				cnt_d   = '0;
				state_d = S_GLM;
			end
			S_GLM: begin
				cmd.op  = OP_LIMB_MUL;
				state_d = S_GLW;
			end
			S_GLW: begin
				cmd.op = OP_LIMB_WR;
				cnt_d  = cnt_q + 6'd1;
				state_d = (cnt_q == 6'(ANGLE_LIMBS - 1)) ? S_MFIN : S_GLM;
			end
			S_MFIN: begin
				cmd.op  = OP_MFIN;
				state_d = S_X2M;
			end
			S_X2M: begin
				cmd.op  = OP_X2_MUL;
				k_d     = '0;
				state_d = status.skip_jump ? S_DEC : S_X2W;
			end
			S_X2W: begin
				cmd.op  = OP_X2_WR;
				state_d = S_CM;
			end
			S_CM: begin
				cmd.op  = OP_C_MUL;
				state_d = S_CDL;
			end
			S_CDL: begin
				cmd.op  = OP_CDIV_LOAD;
				cnt_d   = '0;
				state_d = S_CLM;
			end
			S_CLM: begin
				cmd.op  = OP_LIMB_MUL;
				state_d = S_CLW;
			end
			S_CLW: begin
				cmd.op = OP_LIMB_WR;
				cnt_d  = cnt_q + 6'd1;
				state_d = (cnt_q == 6'(COS_LIMBS - 1)) ? S_CW : S_CLM;
			end
			S_CW: begin
				cmd.op  = OP_CW;
				k_d     = k_q + 3'd1;
				state_d = (k_q == 3'(COS_TERMS - 1)) ? S_DEC : S_CM;
			end
			S_DEC: begin
				cmd.op  = OP_DECIDE;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!status.out_busy) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

endmodule

/* rtl/quaternion_sample_glitch_filter.sv */
// Top level of the quaternion sample glitch filter: controller, datapath and ports.
//
//   channel  direction  beat
//   in_ch    sink       one raw sample with read flag, gyro rates and timestamp
//   out_ch   source     verdict, held quaternion and counters after the step
//   cfg      write      cfg_we, cfg_index, cfg_wdata; eight registers, no read-back
//
// One sample at a time: when the sample is kept as is, it passes from the accepting cycle to
// the result write through the norm, the dot product, the division by 125 and six cosine
// terms. A renormalization adds a 31-step square root and four divisions by the root. A norm
// reject goes straight to the result write, and a step whose half angle reaches a right
// angle skips the cosine.
// Reset restores the held quaternion to identity and clears all counters.
// A result waits in the output register while the next sample is taken; the step
// that writes the following result stalls until that beat is taken.
module quaternion_sample_glitch_filter
	import qsgf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	qsgf_in_if.sink     in_ch,
	qsgf_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [32:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	qsgf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	qsgf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule
